FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the GPS smoother.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk, with the check off during rst.
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/gpsk_pkg.sv
// Package with field widths, register codes and constants of the GPS smoother.
package gpsk_pkg;

   localparam int FRAC_BITS_DEF = 40;

   localparam int LAT_W      = 31;
   localparam int LON_W      = 32;
   localparam int QUAL_W     = 4;
   localparam int NOISE_W    = 41;
   localparam int OFS_W      = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 41;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_OFFSET        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LON_OFFSET        = 2'd3;

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 41'd109951;
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 41'd1099512;
   localparam logic [OFS_W-1:0]   LAT_OFFSET_RST        = 21'h1FF768; // -2200
   localparam logic [OFS_W-1:0]   LON_OFFSET_RST        = 21'd0;

   localparam logic signed [LAT_W:0] LAT_LIM = 32'sd900000000;
   localparam logic signed [LON_W:0] LON_LIM = 33'sd1800000000;

   localparam logic [QUAL_W-1:0] QUAL_NO_FIX = 4'd0;

endpackage

FILE: rtl/gpsk_smul.sv
// Bit-serial shift-add multiplier: one multiplier bit per step, LSB first.
module gpsk_smul #(
   parameter int A_W = 32,
   parameter int B_W = 41
) (
   input  logic               clock,
   input  logic               load,
   input  logic               step,
   input  logic [A_W-1:0]     mcand,
   input  logic [B_W-1:0]     mplier,
   output logic [A_W+B_W-1:0] prod
);

   logic [A_W-1:0]     a_ff, a_in;
   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [A_W:0]       sum;

   always_comb begin
      sum     = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, a_ff} : {(A_W+1){1'b0}});
      a_in    = a_ff;
      prod_in = prod_ff;
      if (load) begin
         a_in    = mcand;
         prod_in = {{A_W{1'b0}}, mplier};
      end else if (step) begin
         // add into the upper half, then shift the whole word right
         prod_in = {sum, prod_ff[B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/gps_position_kalman_smoother_top.sv
// Top level of the GPS smoother: scalar Kalman filter on latitude and longitude.
//
// Usage:
//   req_* carries one fix per transaction: lat/lon in 1e-7 degree and a fix
//   quality. A transaction with quality zero is taken and dropped; it gives
//   no result. Each other fix gives exactly one rsp_* transaction with the
//   filtered and the offset-corrected (saturated) coordinates.
//   csr_* writes the noise and offset registers, one per cycle; the user
//   must write them only while idle, the block does not enforce it.
// Sequence:
//   A valid fix passes PREP, DIV, MLOAD, MUL, UPD and OUT from acceptance
//   to the result register; a new transaction is taken the cycle after.
//   No new fix is taken while one is in work. The gain divider is restoring,
//   one quotient bit per cycle, and the three products (gain times both
//   position errors, one minus gain times covariance) run on bit-serial
//   multipliers side by side. Zero measurement noise skips the divider.
// Reset: synchronous, active high; loads the register defaults, clears the
//   started flag and sets the covariance to one.
// Stall: the result register holds while rsp_ready is low; the next fix is
//   accepted meanwhile and waits in the last step until the register frees.
`include "assert_macros.svh"

module gps_position_kalman_smoother_top import gpsk_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [LAT_W-1:0]      req_lat_sample,
   input  logic signed [LON_W-1:0]      req_lon_sample,
   input  logic        [QUAL_W-1:0]     req_fix_quality,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [LAT_W-1:0]      rsp_smooth_lat,
   output logic signed [LON_W-1:0]      rsp_smooth_lon,
   output logic signed [LAT_W-1:0]      rsp_adj_lat,
   output logic signed [LON_W-1:0]      rsp_adj_lon,
   input  logic                         csr_write_en,
   input  logic        [CSR_IDX_W-1:0]  csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_wdata
);

   localparam int P_W   = FRAC_BITS + 2;                             // covariance
   localparam int K_W   = FRAC_BITS + 1;                             // gain
   localparam int S_W   = ((P_W > NOISE_W) ? P_W : NOISE_W) + 1;     // p + noise
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   localparam logic [P_W-1:0]   COV_ONE  = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic [K_W-1:0]   K_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(K_W - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MLOAD = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // control
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             started_ff, started_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [NOISE_W-1:0] q_ff, q_in;
   logic [NOISE_W-1:0] r_ff, r_in;
   logic [OFS_W-1:0]   lat_ofs_ff, lat_ofs_in;
   logic [OFS_W-1:0]   lon_ofs_ff, lon_ofs_in;

   // filter state and work registers
   logic [P_W-1:0]   cov_ff, cov_in;
   logic [LAT_W-1:0] est_lat_ff, est_lat_in;
   logic [LON_W-1:0] est_lon_ff, est_lon_in;
   logic [LAT_W-1:0] m_lat_ff, m_lat_in;
   logic [LON_W-1:0] m_lon_ff, m_lon_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [S_W-1:0]   d_ff, d_in;
   logic [S_W-1:0]   rem_ff, rem_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [LAT_W-1:0] mag_lat_ff, mag_lat_in;
   logic [LON_W-1:0] mag_lon_ff, mag_lon_in;
   logic             neg_lat_ff, neg_lat_in;
   logic             neg_lon_ff, neg_lon_in;

   // result register
   logic [LAT_W-1:0] o_flat_ff, o_flat_in;
   logic [LON_W-1:0] o_flon_ff, o_flon_in;
   logic [LAT_W-1:0] o_clat_ff, o_clat_in;
   logic [LON_W-1:0] o_clon_ff, o_clon_in;

   // combinational helpers
   logic             accept;
   logic             out_free;
   logic [P_W-1:0]   cov_eff;
   logic [S_W-1:0]   p_sum;
   logic [P_W-1:0]   p_cap;
   logic [LAT_W:0]   diff_lat;
   logic [LON_W:0]   diff_lon;
   logic [LAT_W:0]   negd_lat;
   logic [LON_W:0]   negd_lon;
   logic [S_W:0]     rem_sh;
   logic [S_W:0]     rem_sub;
   logic             rem_ge;
   logic             mul_load;
   logic             mul_step;
   logic [LAT_W+K_W-1:0] prod_lat;
   logic [LON_W+K_W-1:0] prod_lon;
   logic [P_W+K_W-1:0]   prod_p;
   logic [LAT_W-1:0] delta_lat;
   logic [LON_W-1:0] delta_lon;
   logic [P_W-1:0]   cov_new;
   logic signed [LAT_W:0] corr_lat;
   logic signed [LON_W:0] corr_lon;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // predict step: p = min(p + q, cap); first fix starts from one
   assign cov_eff = started_ff ? cov_ff : COV_ONE;
   assign p_sum   = S_W'(cov_eff) + S_W'(q_ff);
   assign p_cap   = (|p_sum[S_W-1:P_W]) ? {P_W{1'b1}} : p_sum[P_W-1:0];

   // innovation split into sign and magnitude for the unsigned multipliers
   assign diff_lat = {m_lat_ff[LAT_W-1], m_lat_ff} - {est_lat_ff[LAT_W-1], est_lat_ff};
   assign diff_lon = {m_lon_ff[LON_W-1], m_lon_ff} - {est_lon_ff[LON_W-1], est_lon_ff};
   assign negd_lat = -diff_lat;
   assign negd_lon = -diff_lon;

   // restoring divider, one quotient bit per cycle
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_ge  = (rem_sh >= {1'b0, d_ff});
   assign rem_sub = rem_sh - {1'b0, d_ff};

   assign mul_load = (state_ff == ST_MLOAD);
   assign mul_step = (state_ff == ST_MUL);

   gpsk_smul #(.A_W(LAT_W), .B_W(K_W)) u_mul_lat (
      .clock  (clock),
      .load   (mul_load),
      .step   (mul_step),
      .mcand  (mag_lat_ff),
      .mplier (k_ff),
      .prod   (prod_lat)
   );

   gpsk_smul #(.A_W(LON_W), .B_W(K_W)) u_mul_lon (
      .clock  (clock),
      .load   (mul_load),
      .step   (mul_step),
      .mcand  (mag_lon_ff),
      .mplier (k_ff),
      .prod   (prod_lon)
   );

   gpsk_smul #(.A_W(P_W), .B_W(K_W)) u_mul_cov (
      .clock  (clock),
      .load   (mul_load),
      .step   (mul_step),
      .mcand  (p_ff),
      .mplier (K_ONE - k_ff),
      .prod   (prod_p)
   );

   // round half up on the magnitude; the step never exceeds the magnitude
   assign delta_lat = prod_lat[FRAC_BITS+LAT_W-1:FRAC_BITS] + LAT_W'(prod_lat[FRAC_BITS-1]);
   assign delta_lon = prod_lon[FRAC_BITS+LON_W-1:FRAC_BITS] + LON_W'(prod_lon[FRAC_BITS-1]);
   // (1 - K) * p never exceeds p, so the cap holds without a clamp
   assign cov_new   = prod_p[FRAC_BITS+P_W-1:FRAC_BITS];

   assign corr_lat = $signed({est_lat_ff[LAT_W-1], est_lat_ff})
                   + $signed({{(LAT_W+1-OFS_W){lat_ofs_ff[OFS_W-1]}}, lat_ofs_ff});
   assign corr_lon = $signed({est_lon_ff[LON_W-1], est_lon_ff})
                   + $signed({{(LON_W+1-OFS_W){lon_ofs_ff[OFS_W-1]}}, lon_ofs_ff});

   // configuration writes
   always_comb begin
      q_in       = q_ff;
      r_in       = r_ff;
      lat_ofs_in = lat_ofs_ff;
      lon_ofs_in = lon_ofs_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     q_in       = csr_wdata[NOISE_W-1:0];
            CSR_MEASUREMENT_NOISE: r_in       = csr_wdata[NOISE_W-1:0];
            CSR_LAT_OFFSET:        lat_ofs_in = csr_wdata[OFS_W-1:0];
            CSR_LON_OFFSET:        lon_ofs_in = csr_wdata[OFS_W-1:0];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cov_in       = cov_ff;
      est_lat_in   = est_lat_ff;
      est_lon_in   = est_lon_ff;
      m_lat_in     = m_lat_ff;
      m_lon_in     = m_lon_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      mag_lat_in   = mag_lat_ff;
      mag_lon_in   = mag_lon_ff;
      neg_lat_in   = neg_lat_ff;
      neg_lon_in   = neg_lon_ff;
      o_flat_in    = o_flat_ff;
      o_flon_in    = o_flon_ff;
      o_clat_in    = o_clat_ff;
      o_clon_in    = o_clon_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_fix_quality != QUAL_NO_FIX)) begin
               m_lat_in   = req_lat_sample;
               m_lon_in   = req_lon_sample;
               // first fix: load both estimates from the sample
               if (!started_ff) begin
                  est_lat_in = req_lat_sample;
                  est_lon_in = req_lon_sample;
               end
               started_in = 1'b1;
               p_in       = p_cap;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_lat_in = diff_lat[LAT_W];
            neg_lon_in = diff_lon[LON_W];
            mag_lat_in = diff_lat[LAT_W] ? negd_lat[LAT_W-1:0] : diff_lat[LAT_W-1:0];
            mag_lon_in = diff_lon[LON_W] ? negd_lon[LON_W-1:0] : diff_lon[LON_W-1:0];
            d_in       = S_W'(p_ff) + S_W'(r_ff);
            rem_in     = S_W'(p_ff);
            cnt_in     = '0;
            // zero measurement noise: gain is exactly one, skip the divider
            if (r_ff == '0) begin
               k_in     = K_ONE;
               state_in = ST_MLOAD;
            end else begin
               k_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sub[S_W-1:0] : rem_sh[S_W-1:0];
            k_in   = {k_ff[K_W-2:0], rem_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_MLOAD;
            end
         end
         ST_MLOAD: begin
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            est_lat_in = neg_lat_ff ? (est_lat_ff - delta_lat) : (est_lat_ff + delta_lat);
            est_lon_in = neg_lon_ff ? (est_lon_ff - delta_lon) : (est_lon_ff + delta_lon);
            cov_in     = cov_new;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold here until the result register is free
            if (out_free) begin
               o_flat_in    = est_lat_ff;
               o_flon_in    = est_lon_ff;
               o_clat_in    = (corr_lat > LAT_LIM)  ? LAT_LIM[LAT_W-1:0]
                            : (corr_lat < -LAT_LIM) ? LAT_W'(-LAT_LIM)
                            : corr_lat[LAT_W-1:0];
               o_clon_in    = (corr_lon > LON_LIM)  ? LON_LIM[LON_W-1:0]
                            : (corr_lon < -LON_LIM) ? LON_W'(-LON_LIM)
                            : corr_lon[LON_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cov_ff       <= COV_ONE;
         est_lat_ff   <= '0;
         est_lon_ff   <= '0;
         q_ff         <= PROCESS_NOISE_RST;
         r_ff         <= MEASUREMENT_NOISE_RST;
         lat_ofs_ff   <= LAT_OFFSET_RST;
         lon_ofs_ff   <= LON_OFFSET_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         cov_ff       <= cov_in;
         est_lat_ff   <= est_lat_in;
         est_lon_ff   <= est_lon_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         lat_ofs_ff   <= lat_ofs_in;
         lon_ofs_ff   <= lon_ofs_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      m_lat_ff   <= m_lat_in;
      m_lon_ff   <= m_lon_in;
      p_ff       <= p_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      k_ff       <= k_in;
      mag_lat_ff <= mag_lat_in;
      mag_lon_ff <= mag_lon_in;
      neg_lat_ff <= neg_lat_in;
      neg_lon_ff <= neg_lon_in;
      o_flat_ff  <= o_flat_in;
      o_flon_ff  <= o_flon_in;
      o_clat_ff  <= o_clat_in;
      o_clon_ff  <= o_clon_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_smooth_lat = o_flat_ff;
   assign rsp_smooth_lon = o_flon_ff;
   assign rsp_adj_lat    = o_clat_ff;
   assign rsp_adj_lon    = o_clon_ff;

   `ASSERT_RST(a_fix_starts_work, clock, reset,
      (accept && (req_fix_quality != QUAL_NO_FIX)) |=> (state_ff == ST_PREP))
   `ASSERT_RST(a_rem_below_divisor, clock, reset,
      (state_ff == ST_DIV) |-> (rem_ff < d_ff))
   `ASSERT_RST(a_cov_not_growing, clock, reset,
      (state_ff == ST_UPD) |-> (cov_new <= p_ff))
   `ASSERT_RST(a_started_sticks, clock, reset,
      started_ff |=> started_ff)
   `ASSERT_RST(a_result_posted, clock, reset,
      ((state_ff == ST_OUT) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))

endmodule

FILE: tb/sv/gps_position_kalman_smoother_top_tb.sv
// Self-checking testbench for the GPS position Kalman smoother top level.
`timescale 1ns / 100ps

module gps_position_kalman_smoother_top_tb import gpsk_pkg::*;;

   // Timing of the run. SETTLE_CYCLES covers one valid fix's trip through the
   // block plus slack, before the registers are touched again.
   localparam int          FRAC          = FRAC_BITS_DEF;
   localparam int          SETTLE_CYCLES = 2 * FRAC + 25;
   localparam int          PHASES        = 10;
   localparam int          FIXES_PER_PHS = 165;
   localparam int unsigned RUN_LIMIT_NS  = 12_000_000;

   localparam logic [63:0] ONE_FX  = 64'd1 << FRAC;
   localparam logic [63:0] COV_CAP = (64'd1 << (FRAC + 2)) - 1;

   localparam logic signed [OFS_W-1:0] OFS_MAX = 21'sh0FFFFF;
   localparam logic signed [OFS_W-1:0] OFS_MIN = 21'sh100000;

   typedef struct {
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
      logic [QUAL_W-1:0]       qual;
   } gps_fix_type;

   typedef struct {
      logic signed [LAT_W-1:0] filt_lat;
      logic signed [LON_W-1:0] filt_lon;
      logic signed [LAT_W-1:0] corr_lat;
      logic signed [LON_W-1:0] corr_lon;
   } gps_est_type;

   // Block ports; every input starts at a known value.
   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic signed [LAT_W-1:0] req_lat_sample    = '0;
   logic signed [LON_W-1:0] req_lon_sample    = '0;
   logic [QUAL_W-1:0]       req_fix_quality   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic signed [LAT_W-1:0] rsp_smooth_lat;
   logic signed [LON_W-1:0] rsp_smooth_lon;
   logic signed [LAT_W-1:0] rsp_adj_lat;
   logic signed [LON_W-1:0] rsp_adj_lon;
   logic                    csr_write_en      = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index         = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata         = '0;

   // Fixes waiting to go out, and the estimates the block still owes us.
   gps_fix_type fix_backlog[$];
   gps_est_type estimate_due[$];

   // Tracker copy: shared covariance and the two position estimates.
   bit          trk_started = 1'b0;
   logic [63:0] trk_cov     = ONE_FX;
   longint      trk_lat     = 0;
   longint      trk_lon     = 0;

   // Register copy, loaded with the block's reset values.
   logic [NOISE_W-1:0]      cfg_pnoise  = PROCESS_NOISE_RST;
   logic [NOISE_W-1:0]      cfg_mnoise  = MEASUREMENT_NOISE_RST;
   logic signed [OFS_W-1:0] cfg_lat_ofs = LAT_OFFSET_RST;
   logic signed [OFS_W-1:0] cfg_lon_ofs = LON_OFFSET_RST;

   // Handshake bookkeeping between the sampling and driving edges.
   bit          fix_on_bus = 1'b0;
   bit          fix_taken  = 1'b0;
   bit          est_taken  = 1'b0;
   bit          calm       = 1'b0;
   int unsigned gap_left   = 0;
   int unsigned stall_left = 0;
   gps_fix_type cur_fix;

   int unsigned fixes_taken  = 0;
   int unsigned fixes_dropped = 0;
   int unsigned results_seen = 0;
   int unsigned sat_count    = 0;
   int unsigned unit_gains   = 0;
   int unsigned settings_run = 1;
   int unsigned mismatches   = 0;

   gps_position_kalman_smoother_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_lat_sample    (req_lat_sample),
      .req_lon_sample    (req_lon_sample),
      .req_fix_quality   (req_fix_quality),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_smooth_lat    (rsp_smooth_lat),
      .rsp_smooth_lon    (rsp_smooth_lon),
      .rsp_adj_lat       (rsp_adj_lat),
      .rsp_adj_lon       (rsp_adj_lon),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Gain p/(p+r) as a fraction with FRAC bits; a denominator of zero, or
   // no measurement noise at all, gives exactly one.
   function automatic logic [63:0] kalman_gain(input logic [63:0] cov,
                                               input logic [63:0] rn);
      logic [63:0]  den;
      logic [127:0] num;
      den = cov + rn;
      if (den == 0 || cov >= den) return ONE_FX;
      num = 128'(cov) << FRAC;
      return 64'(num / 128'(den));
   endfunction

   // Move x toward m by |m-x|*k, rounded half away from zero.
   function automatic longint step_toward(input longint x, input longint m,
                                          input logic [63:0] k);
      longint       diff;
      longint       delta;
      logic [63:0]  mag;
      logic [127:0] prod;
      diff  = m - x;
      mag   = (diff < 0) ? -diff : diff;
      prod  = 128'(mag) * 128'(k) + (128'd1 << (FRAC - 1));
      prod  = prod >> FRAC;
      delta = prod[63:0];
      return (diff < 0) ? x - delta : x + delta;
   endfunction

   function automatic longint clamp_coord(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Run one filter update on a valid fix and return the estimate it yields.
   function automatic gps_est_type smooth_fix(input logic signed [LAT_W-1:0] lat_s,
                                              input logic signed [LON_W-1:0] lon_s);
      logic [63:0]  cov;
      logic [63:0]  k;
      logic [127:0] prod;
      longint       raw_lat;
      longint       raw_lon;
      longint       corr_lat;
      longint       corr_lon;
      gps_est_type  est;
      // First fix seeds both estimates and resets the covariance to one.
      if (!trk_started) begin
         trk_lat     = lat_s;
         trk_lon     = lon_s;
         trk_cov     = ONE_FX;
         trk_started = 1'b1;
      end
      cov = trk_cov + 64'(cfg_pnoise);
      if (cov > COV_CAP) cov = COV_CAP;
      k = kalman_gain(cov, 64'(cfg_mnoise));
      if (k == ONE_FX) unit_gains++;
      trk_lat = step_toward(trk_lat, lat_s, k);
      trk_lon = step_toward(trk_lon, lon_s, k);
      prod = 128'(ONE_FX - k) * 128'(cov);
      cov  = 64'(prod >> FRAC);
      if (cov > COV_CAP) cov = COV_CAP;
      trk_cov = cov;
      // Offsets apply after filtering; only the corrected pair saturates.
      raw_lat  = trk_lat + longint'(cfg_lat_ofs);
      raw_lon  = trk_lon + longint'(cfg_lon_ofs);
      corr_lat = clamp_coord(raw_lat, longint'(LAT_LIM));
      corr_lon = clamp_coord(raw_lon, longint'(LON_LIM));
      if (corr_lat != raw_lat || corr_lon != raw_lon) sat_count++;
      est.filt_lat = trk_lat[LAT_W-1:0];
      est.filt_lon = trk_lon[LON_W-1:0];
      est.corr_lat = corr_lat[LAT_W-1:0];
      est.corr_lon = corr_lon[LON_W-1:0];
      return est;
   endfunction

   function automatic void push_fix(input logic signed [LAT_W-1:0] lat,
                                    input logic signed [LON_W-1:0] lon,
                                    input logic [QUAL_W-1:0] qual);
      gps_fix_type f;
      f.lat  = lat;
      f.lon  = lon;
      f.qual = qual;
      fix_backlog.push_back(f);
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s, result %0d: expected %0d, got %0d",
                     field, results_seen, want, got);
      end
   endtask

   // Single register write; the tracker copy follows at the same moment
   // since the block is idle whenever this runs.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         CSR_PROCESS_NOISE:     cfg_pnoise  = val[NOISE_W-1:0];
         CSR_MEASUREMENT_NOISE: cfg_mnoise  = val[NOISE_W-1:0];
         CSR_LAT_OFFSET:        cfg_lat_ofs = val[OFS_W-1:0];
         CSR_LON_OFFSET:        cfg_lon_ofs = val[OFS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Load all four registers; junk goes into the unused upper offset bits.
   task automatic load_cfg(input logic [NOISE_W-1:0] pn, input logic [NOISE_W-1:0] mn,
                           input logic signed [OFS_W-1:0] lat_ofs,
                           input logic signed [OFS_W-1:0] lon_ofs);
      write_reg(CSR_PROCESS_NOISE, pn);
      write_reg(CSR_MEASUREMENT_NOISE, mn);
      write_reg(CSR_LAT_OFFSET, {20'($urandom), lat_ofs});
      write_reg(CSR_LON_OFFSET, {20'($urandom), lon_ofs});
      settings_run++;
   endtask

   // Hold the sender until every owed estimate is back, then let any
   // dropped fix still inside the block clear out.
   task automatic drain();
      while (fix_backlog.size() != 0 || fix_on_bus || estimate_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: present one fix per transaction, then idle for a
   // drawn number of cycles before the next one (none in calm phases).
   always @(negedge clock) begin : fix_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fix_on_bus && fix_taken) fix_on_bus = 1'b0;
         fix_taken = 1'b0;
         if (!fix_on_bus) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (fix_backlog.size() != 0) begin
               cur_fix    = fix_backlog.pop_front();
               fix_on_bus = 1'b1;
               gap_left   = calm ? 0 : $urandom_range(0, 8);
               req_lat_sample  <= cur_fix.lat;
               req_lon_sample  <= cur_fix.lon;
               req_fix_quality <= cur_fix.qual;
            end
         end
         req_valid <= fix_on_bus;
      end
   end

   // Result backpressure: after each result, hold ready low for a drawn
   // number of cycles.
   always @(negedge clock) begin : rsp_pacer
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (est_taken) begin
            stall_left = calm ? 0 : $urandom_range(0, 8);
            est_taken  = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // Monitor: predict on every accepted valid fix, check every accepted result
   // against the oldest owed estimate.
   always @(posedge clock) begin : result_monitor
      gps_est_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            fix_taken = 1'b1;
            fixes_taken++;
            if (req_fix_quality == QUAL_NO_FIX)
               fixes_dropped++;
            else
               estimate_due.push_back(smooth_fix(req_lat_sample, req_lon_sample));
         end
         if (rsp_valid && rsp_ready) begin
            est_taken = 1'b1;
            results_seen++;
            if (estimate_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %0d: lat %0d lon %0d", results_seen,
                           rsp_smooth_lat, rsp_smooth_lon);
            end else begin
               want = estimate_due.pop_front();
               check_field("smooth_lat", want.filt_lat, rsp_smooth_lat);
               check_field("smooth_lon", want.filt_lon, rsp_smooth_lon);
               check_field("adj_lat", want.corr_lat, rsp_adj_lat);
               check_field("adj_lon", want.corr_lon, rsp_adj_lon);
            end
         end
      end
   end

   // Stimulus: directed fixes at reset settings, then random phases, each
   // under its own register setting and drained before the next write.
   initial begin : stimulus
      int unsigned sel;
      int          valid_fixes;
      int          base_lat;
      int          base_lon;
      logic [3:0]  q;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fix with no quality ahead of the first real fix: drop it, no seed.
      push_fix(31'sh40000000, 32'sh7FFFFFFF, QUAL_NO_FIX);
      // First fix seeds the estimate at the range maxima.
      push_fix(31'sd900000000, 32'sd1800000000, 4'd1);
      push_fix(-31'sd900000000, -32'sd1800000000, 4'd15);
      // Samples at the field extremes, outside the legal range.
      push_fix(31'sh40000000, 32'sh80000000, 4'd8);
      push_fix(31'sh3FFFFFFF, 32'sh7FFFFFFF, 4'd4);
      push_fix('0, '0, QUAL_NO_FIX);
      // Every nonzero quality counts as a fix.
      for (int i = 1; i <= 15; i++)
         push_fix(31'(123456789 + i * 40), 32'(-98765432 - i * 25), 4'(i));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: load_cfg('0, 41'd1, OFS_MAX, OFS_MAX);
            1: load_cfg(41'd1 << 40, 41'd1 << 40, OFS_MIN, OFS_MIN);
            2: load_cfg('1, '1, 21'sd900000, -21'sd900000);
            // No noise at all: the covariance collapses and the gain's
            // denominator goes to zero.
            3: load_cfg('0, '0, -21'sd900000, 21'sd900000);
            // No measurement noise with a live covariance: gain one.
            4: load_cfg(41'($urandom) + 41'd1, '0, '0, '0);
            5: load_cfg(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST,
                        LAT_OFFSET_RST, LON_OFFSET_RST);
            default:
               load_cfg(41'({$urandom, $urandom} >> $urandom_range(23, 63)),
                        41'({$urandom, $urandom} >> $urandom_range(23, 63)),
                        21'(int'($urandom_range(0, 1800000)) - 900000),
                        21'(int'($urandom_range(0, 1800000)) - 900000));
         endcase
         calm = (ph % 3 == 1);

         // Pick a track: sometimes hugging the range edges so the
         // corrected outputs saturate, otherwise anywhere on the globe.
         if ($urandom_range(0, 2) == 0) begin
            base_lat = ($urandom_range(0, 1) ? 1 : -1)
                       * (900000000 - int'($urandom_range(0, 2000)));
            base_lon = ($urandom_range(0, 1) ? 1 : -1)
                       * (1800000000 - int'($urandom_range(0, 2000)));
         end else begin
            base_lat = int'($urandom_range(0, 1800000000)) - 900000000;
            base_lon = int'($urandom_range(0, 32'd3600000000) - 32'd1800000000);
         end

         valid_fixes = 0;
         while (valid_fixes < FIXES_PER_PHS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
               push_fix(31'($urandom), 32'($urandom), QUAL_NO_FIX);
            end else begin
               q = 4'($urandom_range(1, 15));
               if (sel < 78) begin
                  // Drifting track with measurement jitter.
                  base_lat += int'($urandom_range(0, 100)) - 50;
                  base_lon += int'($urandom_range(0, 100)) - 50;
                  push_fix(31'(base_lat + int'($urandom_range(0, 6000)) - 3000),
                           32'(base_lon + int'($urandom_range(0, 6000)) - 3000), q);
               end else if (sel < 92) begin
                  push_fix(31'(int'($urandom_range(0, 1800000000)) - 900000000),
                           32'($urandom_range(0, 32'd3600000000) - 32'd1800000000), q);
               end else begin
                  push_fix(31'($urandom), 32'($urandom), q);
               end
               valid_fixes++;
            end
         end
         drain();
      end

      if (estimate_due.size() != 0) mismatches++;
      $display("Sent %0d fix transactions (%0d with no fix) under %0d register settings",
               fixes_taken, fixes_dropped, settings_run);
      $display("Checked %0d results: %0d saturated corrections, %0d unit-gain updates",
               results_seen, sat_count, unit_gains);
      if (mismatches == 0)
         $display("gps_position_kalman_smoother_top_tb: clean");
      else
         $display("gps_position_kalman_smoother_top_tb: errors");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      #RUN_LIMIT_NS;
      $display("gps_position_kalman_smoother_top_tb: errors");
      $finish;
   end

endmodule
